// File: rtl/ire_pkg.sv
// Shared types, numeral codes and digit pattern functions for the Roman numeral encoder.
package ire_pkg;

  localparam logic [11:0] MAX_VALUE = 12'd3999;

  localparam logic [6:0] CH_M = 7'h4D;
  localparam logic [6:0] CH_D = 7'h44;
  localparam logic [6:0] CH_C = 7'h43;
  localparam logic [6:0] CH_L = 7'h4C;
  localparam logic [6:0] CH_X = 7'h58;
  localparam logic [6:0] CH_V = 7'h56;
  localparam logic [6:0] CH_I = 7'h49;
  localparam logic [6:0] CH_NONE = 7'h00;

  localparam logic [1:0] SYM_UNIT = 2'd0;
  localparam logic [1:0] SYM_FIVE = 2'd1;
  localparam logic [1:0] SYM_NEXT = 2'd2;

  localparam logic [1:0] POS_ONES      = 2'd0;
  localparam logic [1:0] POS_TENS      = 2'd1;
  localparam logic [1:0] POS_HUNDREDS  = 2'd2;
  localparam logic [1:0] POS_THOUSANDS = 2'd3;

  // digit[3] thousands, digit[2] hundreds, digit[1] tens, digit[0] ones
  typedef struct packed {
    logic            range_error;
    logic [3:0][3:0] digit;
  } ire_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ire_qstat_t;

  function automatic logic [2:0] digit_len(input logic [3:0] d);
    logic [2:0] n;
    unique case (d)
      4'd1:    n = 3'd1;
      4'd2:    n = 3'd2;
      4'd3:    n = 3'd3;
      4'd4:    n = 3'd2;
      4'd5:    n = 3'd1;
      4'd6:    n = 3'd2;
      4'd7:    n = 3'd3;
      4'd8:    n = 3'd4;
      4'd9:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] digit_sym(input logic [3:0] d, input logic [1:0] idx);
    logic [1:0] s;
    priority if (d < 4'd4) begin
      s = SYM_UNIT;
    end else if (d == 4'd4) begin
      s = (idx == 2'd0) ? SYM_UNIT : SYM_FIVE;
    end else if (d == 4'd9) begin
      s = (idx == 2'd0) ? SYM_UNIT : SYM_NEXT;
    end else begin
      s = (idx == 2'd0) ? SYM_FIVE : SYM_UNIT;
    end
    return s;
  endfunction

  function automatic logic [6:0] numeral(input logic [1:0] sym, input logic [1:0] pos);
    logic [6:0] c;
    unique case (pos)
      POS_ONES: begin
        unique case (sym)
          SYM_UNIT: c = CH_I;
          SYM_FIVE: c = CH_V;
          default:  c = CH_X;
        endcase
      end
      POS_TENS: begin
        unique case (sym)
          SYM_UNIT: c = CH_X;
          SYM_FIVE: c = CH_L;
          default:  c = CH_C;
        endcase
      end
      POS_HUNDREDS: begin
        unique case (sym)
          SYM_UNIT: c = CH_C;
          SYM_FIVE: c = CH_D;
          default:  c = CH_M;
        endcase
      end
      default: c = CH_M;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/ire_front.sv
// Front end: takes input beats, splits the value into decimal digits and flags range errors.
module ire_front import ire_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [11:0] value,
  input  ire_qstat_t qstat,
  output logic       push,
  output ire_item_t  push_item
);

  logic        held;
  logic [11:0] held_value;
  logic        is_err;
  logic        is_zero;
  logic        drop;
  logic        accept;
  logic [1:0]  th;
  logic [11:0] th_base;
  logic [9:0]  r1;
  logic [3:0]  hu;
  logic [9:0]  r2_full;
  logic [6:0]  r2;
  logic [3:0]  te;
  logic [3:0]  on;

  assign is_err  = held_value > MAX_VALUE;
  assign is_zero = held_value == 12'd0;
  assign drop    = held && is_zero;
  assign push    = held && !is_zero && !qstat.full;
  assign in_stall = held && !is_zero && qstat.full;
  assign accept  = in_valid && !in_stall;

  always_comb begin
    priority if (held_value >= 12'd3000) begin
      th = 2'd3;
      th_base = 12'd3000;
    end else if (held_value >= 12'd2000) begin
      th = 2'd2;
      th_base = 12'd2000;
    end else if (held_value >= 12'd1000) begin
      th = 2'd1;
      th_base = 12'd1000;
    end else begin
      th = 2'd0;
      th_base = 12'd0;
    end
  end

  always_comb begin
    logic [11:0] diff;
    diff = held_value - th_base;
    r1 = diff[9:0];
    hu = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (r1 >= 10'(k * 100)) hu = 4'(k);
    end
    r2_full = r1 - 10'(hu) * 10'd100;
    r2 = r2_full[6:0];
    te = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (r2 >= 7'(k * 10)) te = 4'(k);
    end
    on = 4'(r2 - 7'(te) * 7'd10);
  end

  always_comb begin
    push_item = '0;
    if (is_err) begin
      push_item.range_error = 1'b1;
    end else begin
      push_item.digit[POS_THOUSANDS] = {2'b00, th};
      push_item.digit[POS_HUNDREDS]  = hu;
      push_item.digit[POS_TENS]      = te;
      push_item.digit[POS_ONES]      = on;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (drop || push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_value <= value;
    end
  end

endmodule

// File: rtl/ire_queue.sv
// Two-entry queue of digit items between front and back end.
module ire_queue import ire_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  ire_item_t  push_item,
  input  logic       pop,
  output ire_item_t  head,
  output ire_qstat_t qstat
);

  ire_item_t  entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head        = entry[rd_ptr];
  assign qstat.full  = count == 2'd2;
  assign qstat.empty = count == 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

endmodule

// File: rtl/ire_back.sv
// Back end: walks the digits of one item and emits one numeral character per beat.
module ire_back import ire_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ire_item_t  head,
  input  ire_qstat_t qstat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] numeral_char,
  output logic       last_char,
  output logic       range_error
);

  logic       busy;
  ire_item_t  cur_r;
  logic [1:0] idx;
  ire_item_t  cur;
  ire_item_t  nxt;
  logic       have;
  logic       emit;
  logic [1:0] pos;
  logic       lower_zero;
  logic [2:0] len;
  logic [6:0] ch;
  logic       done;
  logic       last;

  assign cur  = busy ? cur_r : head;
  assign have = busy || !qstat.empty;
  assign emit = have && (!out_valid || !out_stall);
  assign pop  = emit && !busy;

  always_comb begin
    pos = POS_ONES;
    for (int j = 0; j < 4; j++) begin
      if (cur.digit[j] != 4'd0) pos = 2'(j);
    end
    lower_zero = 1'b1;
    for (int j = 0; j < 4; j++) begin
      if (2'(j) < pos && cur.digit[j] != 4'd0) lower_zero = 1'b0;
    end
  end

  always_comb begin
    if (pos == POS_THOUSANDS) begin
      len = {1'b0, cur.digit[POS_THOUSANDS][1:0]};
      ch  = CH_M;
    end else begin
      len = digit_len(cur.digit[pos]);
      ch  = numeral(digit_sym(cur.digit[pos], idx), pos);
    end
    done = ({1'b0, idx} + 3'd1) == len;
    last = cur.range_error || (done && lower_zero);
    nxt  = cur;
    if (done) nxt.digit[pos] = 4'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (emit) begin
        out_valid <= 1'b1;
        busy      <= !last;
        idx       <= (last || done) ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cur_r        <= nxt;
      numeral_char <= cur.range_error ? CH_NONE : ch;
      last_char    <= last;
      range_error  <= cur.range_error;
    end
  end

endmodule

// File: rtl/integer_to_roman_numeral_encoder.sv
// Top level of the integer to Roman numeral encoder.
// Input channel: in_valid/in_stall carry one 12-bit value per beat.
// Output channel: out_valid/out_stall carry one ASCII numeral per beat,
// most significant part first; last_char marks the final beat of a value.
// Values above 3999 give a single beat with range_error set, numeral 0.
// A value of zero is consumed and produces no output beats.
// The first character of a value passes the input register, the digit split
// into the queue and the character sequencer into the output register.
// Throughput: one character per cycle while out_stall is low; a value gives
// 1 to 15 characters, set by its numeral length (3888 is the longest); the next
// value's first character follows the previous last one with no gap.
// The two-entry queue lets the front split up to two values ahead while
// the back end is still emitting.
// Reset clears the input register, queue and sequencer; no beats are lost
// in flight afterwards. A stall on the output holds the current character;
// the queue then fills and in_stall rises.
module integer_to_roman_numeral_encoder import ire_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  numeral_char,
  output logic        last_char,
  output logic        range_error
);

  ire_qstat_t qstat;
  ire_item_t  push_item;
  ire_item_t  head;
  logic       push;
  logic       pop;

  ire_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item)
  );

  ire_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  ire_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .qstat        (qstat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .numeral_char (numeral_char),
    .last_char    (last_char),
    .range_error  (range_error)
  );

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> last_char && numeral_char == CH_NONE)
    else $error("range error beat not a lone zero beat");

  a_char_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !range_error |-> numeral_char != CH_NONE)
    else $error("numeral beat without a character");

  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue full and empty at once");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

endmodule

// File: test/testbench.sv
// Self-checking testbench for the integer to Roman numeral encoder.
module testbench import ire_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
    logic       err;
  } roman_beat_t;

  class roman_scoreboard;
    roman_beat_t expected_beats[$];
    int unsigned failures;

    function new();
      failures = 0;
    endfunction

    function void push_beat(logic [6:0] ch, logic last, logic err);
      roman_beat_t b;
      b.ch = ch;
      b.last = last;
      b.err = err;
      expected_beats.insert(expected_beats.size(), b);
    endfunction

    function void add_digit(int unsigned d, logic [6:0] unit_ch, logic [6:0] five_ch,
                            logic [6:0] next_ch);
      if (d == 4) begin
        push_beat(unit_ch, 1'b0, 1'b0);
        push_beat(five_ch, 1'b0, 1'b0);
      end else if (d == 9) begin
        push_beat(unit_ch, 1'b0, 1'b0);
        push_beat(next_ch, 1'b0, 1'b0);
      end else if (d >= 5) begin
        push_beat(five_ch, 1'b0, 1'b0);
        repeat (d - 5) push_beat(unit_ch, 1'b0, 1'b0);
      end else begin
        repeat (d) push_beat(unit_ch, 1'b0, 1'b0);
      end
    endfunction

    // Predicts the numeral run for one accepted value.
    function void note_value(logic [11:0] v);
      int unsigned n;
      int unsigned base;
      n = v;
      base = expected_beats.size();
      if (v > MAX_VALUE) begin
        push_beat(CH_NONE, 1'b1, 1'b1);
      end else begin
        repeat (n / 1000) push_beat(CH_M, 1'b0, 1'b0);
        add_digit((n / 100) % 10, CH_C, CH_D, CH_M);
        add_digit((n / 10) % 10, CH_X, CH_L, CH_C);
        add_digit(n % 10, CH_I, CH_V, CH_X);
        if (expected_beats.size() > base) expected_beats[expected_beats.size() - 1].last = 1'b1;
      end
    endfunction

    function void check_beat(logic [6:0] ch, logic last, logic err);
      roman_beat_t exp_b;
      if (expected_beats.size() == 0) begin
        $error("unexpected output beat: numeral_char %h last_char %b range_error %b",
               ch, last, err);
        failures++;
      end else begin
        exp_b = expected_beats.pop_front();
        if (ch !== exp_b.ch) begin
          $error("numeral_char: expected %h, got %h", exp_b.ch, ch);
          failures++;
        end
        if (last !== exp_b.last) begin
          $error("last_char: expected %b, got %b", exp_b.last, last);
          failures++;
        end
        if (err !== exp_b.err) begin
          $error("range_error: expected %b, got %b", exp_b.err, err);
          failures++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] value = 12'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  numeral_char;
  logic        last_char;
  logic        range_error;

  roman_scoreboard sb;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  logic            hold_req = 1'b0;
  int unsigned     hold_left = 0;

  integer_to_roman_numeral_encoder DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .numeral_char (numeral_char),
    .last_char    (last_char),
    .range_error  (range_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Output side: check each accepted beat, then choose next stall.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_beat(numeral_char, last_char, range_error);
      if (hold_req) begin
        hold_left = 300;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic send_value(input logic [11:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      value <= 12'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_value(v);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned count, input int unsigned idle_pct,
                           input int unsigned stall_pct);
    int unsigned r;
    logic [11:0] v;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 70) v = 12'($urandom_range(3999, 1));
      else if (r < 80) v = 12'($urandom_range(4095, 4000));
      else if (r < 85) v = 12'd0;
      else v = 12'($urandom);
      send_value(v);
    end
  endtask

  initial begin
    logic [11:0] directed[$];
    directed = '{12'd0, 12'd1, 12'd3, 12'd4, 12'd5, 12'd8, 12'd9, 12'd10, 12'd14, 12'd40,
                 12'd49, 12'd90, 12'd99, 12'd400, 12'd444, 12'd500, 12'd900, 12'd999,
                 12'd1000, 12'd1994, 12'd2048, 12'd3888, 12'd3999, 12'd4000, 12'd4095};
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_value(directed[i]);
    wait_drained();

    run_phase(100, 0, 0);
    run_phase(100, 64, 0);
    wait_drained();
    run_phase(100, 0, 64);
    run_phase(100, 17, 17);

    // long output hold while input keeps coming, to fill the pipe
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    run_phase(20, 0, 0);
    wait_drained();

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("integer_to_roman_numeral_encoder regression: pass");
    end else begin
      $display("integer_to_roman_numeral_encoder regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("integer_to_roman_numeral_encoder regression: fail");
    $finish;
  end

endmodule

// File: filelist.f
rtl/ire_pkg.sv
rtl/ire_front.sv
rtl/ire_queue.sv
rtl/ire_back.sv
rtl/integer_to_roman_numeral_encoder.sv
test/testbench.sv
